// File: hw/rtl/tsm_pkg.sv
package tsm_pkg;

   // element width of both buffers and of the merged output
   localparam int ELEM_W = 32;

   // item kinds on the request side (carried in req_tuser)
   localparam logic [1:0] KIND_APPEND_A = 2'd0;
   localparam logic [1:0] KIND_APPEND_B = 2'd1;
   localparam logic [1:0] KIND_MERGE    = 2'd2;

   // bit positions of the result flags in rsp_tuser
   localparam int RSP_USER_W      = 2;
   localparam int RSP_BIT_EMPTY   = 0;
   localparam int RSP_BIT_DROPPED = 1;

   typedef logic signed [ELEM_W-1:0] elem_type;

endpackage

// File: hw/rtl/tsm_ram.sv
module tsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/tsm_cmp.sv
module tsm_cmp
   import tsm_pkg::*;
(
   input  elem_type head_a,
   input  elem_type head_b,
   output logic     a_wins
);

   // A wins a tie
   assign a_wins = (head_a <= head_b);

endmodule

// File: hw/rtl/two_way_sorted_merge_top.sv
// Two-way merge of sorted sequences.
//
// Request channel (req_*): each item carries a kind in req_tuser and a signed
// element in req_tdata. Kind append-A / append-B stores the element at the
// tail of buffer A / B (DEPTH entries each); an element that meets a full
// buffer is dropped and a sticky drop flag is set. Kind merge starts a walk
// that emits the merge of A and B, smaller head first, A winning ties. The
// unused kind is accepted and ignored.
//
// Response channel (rsp_*): one item per merged element, rsp_tlast on the
// final one. If both buffers were empty, one item with data zero, tlast and
// the empty flag. The drop flag rides on every item of the run, then both
// buffers and the flag are cleared.
//
// Walk: for each element the merge walk first addresses the two buffer RAMs,
// then compares the registered heads in the one shared comparator. An output
// register holds the current item; while the receiver stalls, the walk waits
// on it and req_tready stays low until the walk ends. Loads proceed while
// the last item waits; reset clears buffers, drop flag, valid.
module two_way_sorted_merge_top
   import tsm_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [31:0] value
   input  logic [1:0]            req_tuser,   // [1:0] kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // [31:0] out_value
   output logic                  rsp_tlast,   // last
   output logic [RSP_USER_W-1:0] rsp_tuser    // [0] empty_res, [1] dropped
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_PICK,
      ST_EMPTY
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_a_ff, count_a_in;
   logic [CW-1:0]   count_b_ff, count_b_in;
   logic [CW-1:0]   ia_ff, ia_in;
   logic [CW-1:0]   ib_ff, ib_in;
   logic            overflow_ff, overflow_in;
   logic            rsp_valid_ff, rsp_valid_in;
   elem_type        rsp_value_ff, rsp_value_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            rsp_empty_ff, rsp_empty_in;
   logic            rsp_dropped_ff, rsp_dropped_in;

   logic            wr_a, wr_b;
   elem_type        head_a, head_b;
   logic            a_wins;
   logic            a_live, b_live, take_a, walk_last, rsp_free, req_fire;
   logic [CW:0]     total, pos_next;

   // buffers: write at the tail count, read at the walk pointer
   tsm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH), .AW(AW)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (count_a_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_addr (ia_ff[AW-1:0]),
      .rd_data (head_a)
   );

   tsm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH), .AW(AW)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (count_b_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_addr (ib_ff[AW-1:0]),
      .rd_data (head_b)
   );

   tsm_cmp u_cmp (
      .head_a (head_a),
      .head_b (head_b),
      .a_wins (a_wins)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // store only when the buffer has room
   assign wr_a = req_fire && (req_tuser == KIND_APPEND_A) && (count_a_ff < CW'(DEPTH));
   assign wr_b = req_fire && (req_tuser == KIND_APPEND_B) && (count_b_ff < CW'(DEPTH));

   assign a_live    = (ia_ff < count_a_ff);
   assign b_live    = (ib_ff < count_b_ff);
   assign take_a    = a_live && (!b_live || a_wins);
   assign total     = {1'b0, count_a_ff} + {1'b0, count_b_ff};
   assign pos_next  = {1'b0, ia_ff} + {1'b0, ib_ff} + (CW+1)'(1);
   assign walk_last = (pos_next == total);

   always_comb begin
      state_in       = state_ff;
      count_a_in     = count_a_ff;
      count_b_in     = count_b_ff;
      ia_in          = ia_ff;
      ib_in          = ib_ff;
      overflow_in    = overflow_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_value_in   = rsp_value_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_dropped_in = rsp_dropped_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  KIND_APPEND_A: begin
                     if (wr_a) count_a_in = count_a_ff + CW'(1);
                     else overflow_in = 1'b1;
                  end
                  KIND_APPEND_B: begin
                     if (wr_b) count_b_in = count_b_ff + CW'(1);
                     else overflow_in = 1'b1;
                  end
                  KIND_MERGE: begin
                     ia_in = '0;
                     ib_in = '0;
                     if (total == '0) state_in = ST_EMPTY;
                     else state_in = ST_FETCH;
                  end
                  default: ; // unused kind: drop
               endcase
            end
         end
         ST_FETCH: begin
            // heads are read this cycle, valid next
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_value_in   = take_a ? head_a : head_b;
               rsp_last_in    = walk_last;
               rsp_empty_in   = 1'b0;
               rsp_dropped_in = overflow_ff;
               if (take_a) ia_in = ia_ff + CW'(1);
               else ib_in = ib_ff + CW'(1);
               if (walk_last) begin
                  count_a_in  = '0;
                  count_b_in  = '0;
                  overflow_in = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_EMPTY: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_value_in   = '0;
               rsp_last_in    = 1'b1;
               rsp_empty_in   = 1'b1;
               rsp_dropped_in = overflow_ff;
               overflow_in    = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff   <= rsp_value_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   assign rsp_tvalid                 = rsp_valid_ff;
   assign rsp_tdata                  = rsp_value_ff;
   assign rsp_tlast                  = rsp_last_ff;
   assign rsp_tuser[RSP_BIT_EMPTY]   = rsp_empty_ff;
   assign rsp_tuser[RSP_BIT_DROPPED] = rsp_dropped_ff;

   // an empty-merge item is always the single, final, zero item
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[RSP_BIT_EMPTY]) |-> (rsp_tlast && rsp_tdata == '0))
      else $error("empty result without last or with nonzero data");

   // fill counts never pass the buffer depth
   assert property (@(posedge clock) disable iff (reset)
      (count_a_ff <= CW'(DEPTH)) && (count_b_ff <= CW'(DEPTH)))
      else $error("buffer count beyond depth");

   // the walk never runs past both tails
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK) |-> (a_live || b_live))
      else $error("merge walk past end of both buffers");

   // a finished walk leaves both buffers empty
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK && rsp_free && walk_last) |=>
         (count_a_ff == '0 && count_b_ff == '0 && state_ff == ST_IDLE))
      else $error("buffers not emptied after merge");

endmodule
